### rtl/xsrng_pkg.sv
// Package for the xorshift128+ ranged generator.
// Holds widths, reset seeds, shift amounts, codes and shared types.
// No dependencies; compile first.
package xsrng_pkg;

   localparam int WORD_W   = 64;
   localparam int RANGE_W  = 32;
   localparam int DIVISOR_W = 33;
   localparam int COUNT_W  = 6;

   localparam int SHIFT_A = 23;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 26;

   localparam logic [WORD_W-1:0] SEED_FIRST_RESET  = 64'h0000_0000_0000_0000;
   localparam logic [WORD_W-1:0] SEED_SECOND_RESET = 64'h5555_5555_5555_5555;

   localparam logic CSR_SEED_FIRST  = 1'b0;
   localparam logic CSR_SEED_SECOND = 1'b1;

   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_ABS   = 2'd1;
   localparam logic [1:0] MODE_BELOW = 2'd2;
   localparam logic [1:0] MODE_RANGE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                 done;
      logic [DIVISOR_W-1:0] rem;
   } div_result_type;

endpackage

### rtl/xsrng_if.sv
// Handshake channel interfaces for the request and response items.
// Depends on xsrng_pkg for field widths.
interface xsrng_req_if
   import xsrng_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic signed [RANGE_W-1:0] bound_low;
   logic signed [RANGE_W-1:0] bound_high;

   modport source (output valid, mode, bound_low, bound_high, input ready);
   modport sink (input valid, mode, bound_low, bound_high, output ready);
endinterface

interface xsrng_rsp_if
   import xsrng_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [WORD_W-1:0]         raw_value;
   logic signed [RANGE_W-1:0] ranged_value;
   logic                      bad_bounds;

   modport source (output valid, raw_value, ranged_value, bad_bounds, input ready);
   modport sink (input valid, raw_value, ranged_value, bad_bounds, output ready);
endinterface

### rtl/xorshift128plus_ranged_rng_top.sv
// Xorshift128+ generator with ranged outputs: one item in, one item out. Each
// accepted request advances the generator once, unless a seed write collides.
// Modes 0 and 1, and requests with bad bounds, respond in the cycle after the
// acceptance. Modes 2 and 3 reduce through one shared restoring divider that
// takes one cycle per dividend bit; its result is registered once it is done.
// The block takes one item at a time and accepts the next once the result is
// taken. A write to either seed register reloads both state words at once.
module xorshift128plus_ranged_rng_top
   import xsrng_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata,
   xsrng_req_if.sink         req_ch,
   xsrng_rsp_if.source       rsp_ch
);

   state_type state_ff, state_in;

   logic [1:0]                mode_ff, mode_in;
   logic signed [RANGE_W-1:0] low_ff, low_in;
   logic [WORD_W-1:0]         raw_ff, raw_in;
   logic signed [RANGE_W-1:0] ranged_ff, ranged_in;
   logic                      bad_ff, bad_in;

   logic                        accept;
   logic [WORD_W-1:0]           raw;
   logic [RANGE_W-2:0]          abs_low;
   logic signed [DIVISOR_W-1:0] low_ext;
   logic signed [DIVISOR_W-1:0] high_ext;
   logic [DIVISOR_W-1:0]        span;
   logic                        bad_req;
   logic                        div_start;
   logic [WORD_W-1:0]           dividend;
   logic [DIVISOR_W-1:0]        divisor;
   div_result_type              div_result;

   xsrng_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (accept),
      .raw       (raw)
   );

   xsrng_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .result   (div_result)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      if (raw[RANGE_W-1:0] == {1'b1, {(RANGE_W-1){1'b0}}}) begin
         abs_low = '1;
      end else if (raw[RANGE_W-1]) begin
         abs_low = (RANGE_W-1)'(-raw[RANGE_W-1:0]);
      end else begin
         abs_low = raw[RANGE_W-2:0];
      end
   end

   assign low_ext  = DIVISOR_W'(req_ch.bound_low);
   assign high_ext = DIVISOR_W'(req_ch.bound_high);
   assign span     = DIVISOR_W'(high_ext - low_ext + DIVISOR_W'(1));

   always_comb begin
      bad_req  = 1'b0;
      dividend = raw;
      divisor  = {1'b0, req_ch.bound_high};
      unique case (req_ch.mode)
         MODE_BELOW: begin
            bad_req = (req_ch.bound_high <= 0);
         end
         MODE_RANGE: begin
            bad_req  = (req_ch.bound_high < req_ch.bound_low);
            dividend = {{(WORD_W-RANGE_W+1){1'b0}}, abs_low};
            divisor  = span;
         end
         default: ;
      endcase
   end

   assign div_start = accept && !bad_req &&
                      (req_ch.mode == MODE_BELOW || req_ch.mode == MODE_RANGE);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      low_in    = low_ff;
      raw_in    = raw_ff;
      ranged_in = ranged_ff;
      bad_in    = bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_ch.mode;
               low_in    = req_ch.bound_low;
               raw_in    = raw;
               bad_in    = bad_req;
               ranged_in = (req_ch.mode == MODE_ABS) ? {1'b0, abs_low} : '0;
               state_in  = div_start ? ST_DIVIDE : ST_RESPOND;
            end
         end
         ST_DIVIDE: begin
            if (div_result.done) begin
               if (mode_ff == MODE_BELOW) begin
                  ranged_in = div_result.rem[RANGE_W-1:0];
               end else begin
                  ranged_in = low_ff + div_result.rem[RANGE_W-1:0];
               end
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      low_ff    <= low_in;
      raw_ff    <= raw_in;
      ranged_ff <= ranged_in;
      bad_ff    <= bad_in;
   end

   assign rsp_ch.valid        = (state_ff == ST_RESPOND);
   assign rsp_ch.raw_value    = raw_ff;
   assign rsp_ch.ranged_value = ranged_ff;
   assign rsp_ch.bad_bounds   = bad_ff;

endmodule

### rtl/xsrng_gen.sv
// Seed registers and the two xorshift128+ state words.
// Depends on xsrng_pkg; gives the output of the next step combinationally.
module xsrng_gen
   import xsrng_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              step,
   output logic [WORD_W-1:0] raw
);

   logic [WORD_W-1:0] seed_first_ff, seed_first_in;
   logic [WORD_W-1:0] seed_second_ff, seed_second_in;
   logic [WORD_W-1:0] word_a_ff, word_a_in;
   logic [WORD_W-1:0] word_b_ff, word_b_in;
   logic [WORD_W-1:0] mix_x;
   logic [WORD_W-1:0] next_b;

   assign mix_x  = word_a_ff ^ (word_a_ff << SHIFT_A);
   assign next_b = mix_x ^ word_b_ff ^ (mix_x >> SHIFT_B) ^ (word_b_ff >> SHIFT_C);
   assign raw    = next_b + word_b_ff;

   always_comb begin
      seed_first_in  = seed_first_ff;
      seed_second_in = seed_second_ff;
      word_a_in      = word_a_ff;
      word_b_in      = word_b_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEED_FIRST:  seed_first_in  = csr_wdata;
            CSR_SEED_SECOND: seed_second_in = csr_wdata;
            default: ;
         endcase
         word_a_in = seed_first_in;
         word_b_in = seed_second_in;
      end else if (step) begin
         word_a_in = word_b_ff;
         word_b_in = next_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_first_ff  <= SEED_FIRST_RESET;
         seed_second_ff <= SEED_SECOND_RESET;
         word_a_ff      <= SEED_FIRST_RESET;
         word_b_ff      <= SEED_SECOND_RESET;
      end else begin
         seed_first_ff  <= seed_first_in;
         seed_second_ff <= seed_second_in;
         word_a_ff      <= word_a_in;
         word_b_ff      <= word_b_in;
      end
   end

endmodule

### rtl/xsrng_div.sv
// Restoring divider, one dividend bit per cycle, remainder only.
// Depends on xsrng_pkg; 64-bit dividend, 33-bit divisor.
module xsrng_div
   import xsrng_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output div_result_type       result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   trial;
   logic                 last_step;

   assign shifted   = {rem_ff, quo_ff[WORD_W-1]};
   assign trial     = shifted - {1'b0, div_ff};
   assign last_step = (count_ff == COUNT_W'(WORD_W - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[WORD_W-2:0], 1'b0};
         rem_in   = trial[DIVISOR_W] ? shifted[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         count_in = count_ff + COUNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

### rtl/xsrng_checker.sv
// Port-level checks for the ranged generator top level.
// Depends on xsrng_pkg; attached to the top level by the bind below.
module xsrng_checker
   import xsrng_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [WORD_W-1:0]         rsp_raw_value,
   input logic signed [RANGE_W-1:0] rsp_ranged_value,
   input logic                      rsp_bad_bounds
);

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response item is pending");

   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted but block did not go busy");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_bounds |-> rsp_ranged_value == 0)
      else $error("bad bounds with nonzero ranged value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_value)
         && $stable(rsp_ranged_value) && $stable(rsp_bad_bounds))
      else $error("stalled response item changed");

endmodule

bind xorshift128plus_ranged_rng_top xsrng_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_raw_value    (rsp_ch.raw_value),
   .rsp_ranged_value (rsp_ch.ranged_value),
   .rsp_bad_bounds   (rsp_ch.bad_bounds)
);

### tb/sv/testbench.sv
// Self-checking bench for xorshift128plus_ranged_rng_top: directed and random draws
// in all four modes across several seed settings, checked against an in-bench model.
// Depends on xsrng_pkg and the channel interfaces of xsrng_if.
`timescale 1ns / 100ps
module testbench;
   import xsrng_pkg::*;

   localparam logic signed [RANGE_W-1:0] MIN_BOUND = 32'sh8000_0000;
   localparam logic signed [RANGE_W-1:0] MAX_BOUND = 32'sh7fff_ffff;
   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   typedef struct {
      logic [WORD_W-1:0]         raw_value;
      logic signed [RANGE_W-1:0] ranged_value;
      logic                      bad_bounds;
   } draw_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_index;
   logic [WORD_W-1:0] csr_wdata;

   xsrng_req_if req_ch();
   xsrng_rsp_if rsp_ch();

   xorshift128plus_ranged_rng_top dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [WORD_W-1:0] seed_a_reg;
   logic [WORD_W-1:0] seed_b_reg;
   logic [WORD_W-1:0] word_a;
   logic [WORD_W-1:0] word_b;
   draw_type          pending_draws[$];
   int                fault_count = 0;
   int                stall_left = 0;
   bit                steady = 1'b0;

   always #5 clock = ~clock;

   function automatic int pick_gap(input int idle_pct);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r >= idle_pct)
         return 0;
      if (r < idle_pct / 8)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [RANGE_W-1:0] fold_low(input logic [WORD_W-1:0] raw);
      logic signed [RANGE_W-1:0] low;
      low = raw[RANGE_W-1:0];
      if (low == MIN_BOUND)
         return MAX_BOUND;
      if (low < 0)
         return -low;
      return low;
   endfunction

   // advance the generator state and reduce the new sum by mode
   function automatic draw_type next_draw(input logic [1:0] mode,
                                          input logic signed [RANGE_W-1:0] lo,
                                          input logic signed [RANGE_W-1:0] hi);
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      longint            span;
      draw_type          d;
      x = word_a;
      y = word_b;
      word_a = y;
      x = x ^ (x << SHIFT_A);
      word_b = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
      d.raw_value = word_b + y;
      d.ranged_value = '0;
      d.bad_bounds = 1'b0;
      case (mode)
         MODE_ABS: begin
            d.ranged_value = fold_low(d.raw_value);
         end
         MODE_BELOW: begin
            if (hi <= 0)
               d.bad_bounds = 1'b1;
            else
               d.ranged_value =
                  RANGE_W'(d.raw_value % {{(WORD_W-RANGE_W){1'b0}}, hi});
         end
         MODE_RANGE: begin
            if (hi < lo) begin
               d.bad_bounds = 1'b1;
            end else begin
               span = longint'(hi) - longint'(lo) + 1;
               d.ranged_value =
                  RANGE_W'(longint'(lo) + longint'(fold_low(d.raw_value)) % span);
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   function automatic logic signed [RANGE_W-1:0] pick_bound();
      case ($urandom_range(0, 7))
         0: return MIN_BOUND;
         1: return MAX_BOUND;
         2: return 0;
         3: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_seed(input logic index, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_SEED_FIRST)
         seed_a_reg = value;
      else
         seed_b_reg = value;
      word_a = seed_a_reg;
      word_b = seed_b_reg;
   endtask

   task automatic send_request(input logic [1:0] mode,
                               input logic signed [RANGE_W-1:0] lo,
                               input logic signed [RANGE_W-1:0] hi);
      @(posedge clock);
      repeat (pick_gap(40)) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.bound_low <= lo;
      req_ch.bound_high <= hi;
      do @(posedge clock); while (!req_ch.ready);
      req_ch.valid <= 1'b0;
      pending_draws.push_back(next_draw(mode, lo, hi));
   endtask

   task automatic wait_drained();
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      logic [1:0]                mode;
      logic signed [RANGE_W-1:0] lo;
      logic signed [RANGE_W-1:0] hi;
      logic signed [RANGE_W-1:0] held;
      mode = $urandom_range(0, 3);
      lo = pick_bound();
      hi = pick_bound();
      if (mode == MODE_BELOW && $urandom_range(0, 4) != 0 && hi <= 0) begin
         hi = {1'b0, hi[RANGE_W-2:0]};
         if (hi == 0)
            hi = 1;
      end
      if (mode == MODE_RANGE && $urandom_range(0, 4) != 0 && hi < lo) begin
         held = hi;
         hi = lo;
         lo = held;
      end
      send_request(mode, lo, hi);
   endtask

   task automatic test_reset_seeds();
      send_request(MODE_RAW, 0, 0);
      send_request(MODE_RAW, MIN_BOUND, MAX_BOUND);
      send_request(MODE_ABS, -1, -1);
      send_request(MODE_BELOW, 0, 1);
      send_request(MODE_BELOW, 0, MAX_BOUND);
      send_request(MODE_BELOW, 0, 0);
      send_request(MODE_BELOW, 0, MIN_BOUND);
      send_request(MODE_RANGE, MIN_BOUND, MAX_BOUND);
      send_request(MODE_RANGE, 7, 7);
      send_request(MODE_RANGE, 5, -5);
      send_request(MODE_RANGE, MAX_BOUND, MAX_BOUND);
      send_request(MODE_RANGE, MIN_BOUND, MIN_BOUND);
      send_request(MODE_RANGE, -20, 20);
      send_request(MODE_RANGE, MAX_BOUND, MIN_BOUND);
      wait_drained();
   endtask

   // first draw after this seeding has the most negative low word
   task automatic test_saturation();
      write_seed(CSR_SEED_FIRST, 64'h1040_0020_8000_4000);
      write_seed(CSR_SEED_SECOND, '0);
      send_request(MODE_ABS, 0, 0);
      wait_drained();
      write_seed(CSR_SEED_SECOND, '0);
      send_request(MODE_RANGE, -3, 3);
      wait_drained();
   endtask

   task automatic test_zero_state();
      write_seed(CSR_SEED_FIRST, '0);
      write_seed(CSR_SEED_SECOND, '0);
      send_request(MODE_RAW, 0, 0);
      send_request(MODE_ABS, 0, 0);
      send_request(MODE_BELOW, 0, 3);
      send_request(MODE_RANGE, -2, 2);
      wait_drained();
   endtask

   task automatic test_seed_reload();
      write_seed(CSR_SEED_FIRST, ALL_ONES);
      write_seed(CSR_SEED_SECOND, ALL_ONES);
      send_request(MODE_RAW, 0, 0);
      send_request(MODE_BELOW, 0, 1000);
      wait_drained();
      write_seed(CSR_SEED_SECOND, 64'h0123_4567_89ab_cdef);
      send_request(MODE_RAW, 0, 0);
      send_request(MODE_ABS, 0, 0);
      wait_drained();
   endtask

   task automatic test_random_draws();
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_seed(CSR_SEED_FIRST, ALL_ONES);
               write_seed(CSR_SEED_SECOND, '0);
            end
            2: begin
               write_seed(CSR_SEED_FIRST, SEED_FIRST_RESET);
               write_seed(CSR_SEED_SECOND, SEED_SECOND_RESET);
            end
            default: begin
               write_seed(CSR_SEED_FIRST, {$urandom, $urandom});
               write_seed(CSR_SEED_SECOND, {$urandom, $urandom});
            end
         endcase
         steady = (phase == 3);
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(0, 49) == 0)
               wait_drained();
            send_random_request();
         end
         steady = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left <= pick_gap(25);
      end
   end

   always @(posedge clock) begin : check_results
      draw_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_draws.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected item: raw %h ranged %0d bad %b",
                        rsp_ch.raw_value, rsp_ch.ranged_value, rsp_ch.bad_bounds);
         end else begin
            want = pending_draws.pop_front();
            if (want.raw_value !== rsp_ch.raw_value ||
                want.ranged_value !== rsp_ch.ranged_value ||
                want.bad_bounds !== rsp_ch.bad_bounds) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: raw %h/%h ranged %0d/%0d bad %b/%b (exp/got)",
                           want.raw_value, rsp_ch.raw_value,
                           want.ranged_value, rsp_ch.ranged_value,
                           want.bad_bounds, rsp_ch.bad_bounds);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SEED_FIRST;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_RAW;
      req_ch.bound_low <= '0;
      req_ch.bound_high <= '0;
      seed_a_reg = SEED_FIRST_RESET;
      seed_b_reg = SEED_SECOND_RESET;
      word_a = SEED_FIRST_RESET;
      word_b = SEED_SECOND_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_seeds();
      test_saturation();
      test_zero_state();
      test_seed_reload();
      test_random_draws();
      wait_drained();
      repeat (70) @(posedge clock);
      if (fault_count == 0 && pending_draws.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
